>>> rtl/bsofi_pkg.sv
// types and constants shared by the order flow imbalance block
`default_nettype none
package bsofi_pkg;

    localparam int PRICE_W = 32;
    localparam int QTY_W   = 32;
    localparam int OFI_W   = 39;
    localparam int MID_W   = 33;
    localparam int TOP_N   = 10;  // deepest imbalance depth kept per side
    localparam int IDX_W   = 4;   // index into the top levels, and their count
    localparam int NDEPTH  = 4;
    localparam int DEPTH_K [NDEPTH] = '{1, 3, 5, 10};

    typedef struct packed {
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic               top;   // stored level inside the top levels
        logic [IDX_W-1:0]   idx;
        logic               over;
        logic               last;
    } t_cmd;

    typedef struct packed {
        logic [OFI_W-1:0] ofi_depth1;
        logic [OFI_W-1:0] ofi_depth3;
        logic [OFI_W-1:0] ofi_depth5;
        logic [OFI_W-1:0] ofi_depth10;
        logic             ofi_valid;
        logic             book_ok;
        logic             oversized;
        logic [MID_W-1:0] mid_twice;
        logic [MID_W-1:0] ask_bid_gap;
    } t_res;

endpackage
`default_nettype wire

>>> rtl/bsofi_ifs.sv
// channel interfaces: level input, result output, configuration write
`default_nettype none
interface bsofi_in_if;
    logic        valid;
    logic        ready;
    logic        side;
    logic [31:0] price;
    logic [31:0] qty;
    logic        present;
    logic        last;
    modport source (output valid, side, price, qty, present, last, input ready);
    modport sink   (input valid, side, price, qty, present, last, output ready);
endinterface

interface bsofi_out_if;
    logic        valid;
    logic        ready;
    logic [38:0] ofi_depth1;
    logic [38:0] ofi_depth3;
    logic [38:0] ofi_depth5;
    logic [38:0] ofi_depth10;
    logic        ofi_valid;
    logic        book_ok;
    logic        oversized;
    logic [32:0] mid_twice;
    logic [32:0] ask_bid_gap;
    modport source (output valid, ofi_depth1, ofi_depth3, ofi_depth5, ofi_depth10,
                    ofi_valid, book_ok, oversized, mid_twice, ask_bid_gap,
                    input ready);
    modport sink   (input valid, ofi_depth1, ofi_depth3, ofi_depth5, ofi_depth10,
                    ofi_valid, book_ok, oversized, mid_twice, ask_bid_gap,
                    output ready);
endinterface

interface bsofi_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] max_qty;
    modport source (output valid, max_qty, input ready);
    modport sink   (input valid, max_qty, output ready);
endinterface
`default_nettype wire

>>> rtl/bsofi_front.sv
// front: accepts levels, counts per side, checks quantity limit, builds commands
`default_nettype none
module bsofi_front #(
    parameter int LEVELS = 10
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    bsofi_in_if.sink         i_lvl,
    bsofi_cfg_if.sink        i_cfg,
    input  wire              i_full,
    output logic             o_push,
    output bsofi_pkg::t_cmd  o_cmd
);
    import bsofi_pkg::*;

    localparam int CW = $clog2(LEVELS + 1);

    logic [CW-1:0]    r_cnt [2];
    logic [QTY_W-1:0] r_max_qty;
    logic [CW-1:0]    cnt_sd;
    logic             store;

    assign i_cfg.ready = 1'b1;
    assign i_lvl.ready = !i_full;
    assign o_push      = i_lvl.valid && !i_full;

    assign cnt_sd = r_cnt[i_lvl.side];
    assign store  = i_lvl.present && (cnt_sd < CW'(LEVELS));

    always_comb begin
        o_cmd.side  = i_lvl.side;
        o_cmd.price = i_lvl.price;
        o_cmd.qty   = i_lvl.qty;
        o_cmd.top   = store && (cnt_sd < CW'(TOP_N));
        o_cmd.idx   = cnt_sd[IDX_W-1:0];
        o_cmd.over  = store && (i_lvl.qty > r_max_qty);
        o_cmd.last  = i_lvl.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt[0]  <= '0;
            r_cnt[1]  <= '0;
            r_max_qty <= '1;
        end else begin
            if (i_cfg.valid) begin
                r_max_qty <= i_cfg.max_qty;
            end
            if (o_push) begin
                if (i_lvl.last) begin
                    r_cnt[0] <= '0;
                    r_cnt[1] <= '0;
                end else if (store) begin
                    r_cnt[i_lvl.side] <= cnt_sd + CW'(1);
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> rtl/bsofi_queue.sv
// two-entry command queue between front and back
`default_nettype none
module bsofi_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  bsofi_pkg::t_cmd  i_cmd,
    input  wire              i_pop,
    output logic             o_full,
    output logic             o_empty,
    output bsofi_pkg::t_cmd  o_cmd
);
    import bsofi_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule
`default_nettype wire

>>> rtl/bsofi_back.sv
// back: matches levels against the previous view, accumulates imbalance, emits results
`default_nettype none
module bsofi_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_empty,
    input  bsofi_pkg::t_cmd  i_cmd,
    output logic             o_pop,
    output logic             o_valid,
    input  wire              i_ready,
    output bsofi_pkg::t_res  o_res
);
    import bsofi_pkg::*;

    typedef enum logic [1:0] {S_POP, S_ACC, S_SWEEP, S_DONE} t_state;

    t_state             r_state;
    t_cmd               r_cmd;
    logic [PRICE_W-1:0] r_cp   [2][TOP_N];
    logic [QTY_W-1:0]   r_cq   [2][TOP_N];
    logic [PRICE_W-1:0] r_pp   [2][TOP_N];
    logic [QTY_W-1:0]   r_pq   [2][TOP_N];
    logic [IDX_W-1:0]   r_ccnt [2];
    logic [IDX_W-1:0]   r_pcnt [2];
    logic               r_seen [2][TOP_N];
    logic [IDX_W-1:0]   r_sidx [2][TOP_N];
    logic [OFI_W-1:0]   r_acc  [NDEPTH];
    logic [TOP_N-1:0]   r_match;
    logic [IDX_W-1:0]   r_j;
    logic               r_over;
    logic               r_valid;
    t_res               r_res;

    logic [TOP_N-1:0]   match;
    logic [QTY_W-1:0]   pq_sel  [NDEPTH];
    logic [QTY_W:0]     delta   [NDEPTH];
    logic [OFI_W-1:0]   delta_x [NDEPTH];
    logic [OFI_W-1:0]   sweep_add [NDEPTH];
    logic               out_free;

    assign o_valid  = r_valid;
    assign o_res    = r_res;
    assign out_free = !r_valid || i_ready;
    assign o_pop    = (r_state == S_POP) && !i_empty;

    // compare the incoming price with each stored previous level of its side
    always_comb begin
        for (int j = 0; j < TOP_N; j++) begin
            match[j] = (r_pp[i_cmd.side][j] == i_cmd.price)
                       && (IDX_W'(j) < r_pcnt[i_cmd.side]);
        end
    end

    // first matching previous level within depth k wins, one pick per depth
    always_comb begin
        for (int k = 0; k < NDEPTH; k++) begin
            pq_sel[k] = '0;
            for (int j = TOP_N - 1; j >= 0; j--) begin
                if (r_match[j] && (j < DEPTH_K[k])) begin
                    pq_sel[k] = r_pq[r_cmd.side][j];
                end
            end
            delta[k]   = {1'b0, r_cmd.qty} - {1'b0, pq_sel[k]};
            delta_x[k] = {{(OFI_W-QTY_W-1){delta[k][QTY_W]}}, delta[k]};
        end
    end

    // previous levels no longer present within depth k are removed
    always_comb begin
        for (int k = 0; k < NDEPTH; k++) begin
            sweep_add[k] = '0;
            for (int s = 0; s < 2; s++) begin
                if ((r_j < r_pcnt[s]) && (r_j < IDX_W'(DEPTH_K[k]))
                        && !(r_seen[s][r_j] && (r_sidx[s][r_j] < IDX_W'(DEPTH_K[k])))) begin
                    if (s == 0) begin
                        sweep_add[k] = sweep_add[k] - {{(OFI_W-QTY_W){1'b0}}, r_pq[s][r_j]};
                    end else begin
                        sweep_add[k] = sweep_add[k] + {{(OFI_W-QTY_W){1'b0}}, r_pq[s][r_j]};
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd   <= i_cmd;
            r_match <= match;
            if (i_cmd.top) begin
                r_cp[i_cmd.side][i_cmd.idx] <= i_cmd.price;
                r_cq[i_cmd.side][i_cmd.idx] <= i_cmd.qty;
                for (int j = 0; j < TOP_N; j++) begin
                    if (match[j] && !r_seen[i_cmd.side][j]) begin
                        r_sidx[i_cmd.side][j] <= i_cmd.idx;
                    end
                end
            end
        end
        if (r_state == S_DONE && out_free) begin
            r_res.oversized <= r_over;
            if (r_over) begin
                r_res.ofi_depth1  <= '0;
                r_res.ofi_depth3  <= '0;
                r_res.ofi_depth5  <= '0;
                r_res.ofi_depth10 <= '0;
                r_res.ofi_valid   <= 1'b0;
                r_res.book_ok     <= 1'b0;
                r_res.mid_twice   <= '0;
                r_res.ask_bid_gap <= '0;
            end else begin
                r_pp <= r_cp;
                r_pq <= r_cq;
                r_res.ofi_depth1  <= r_acc[0];
                r_res.ofi_depth3  <= r_acc[1];
                r_res.ofi_depth5  <= r_acc[2];
                r_res.ofi_depth10 <= r_acc[3];
                r_res.ofi_valid   <= (r_pcnt[0] != '0) || (r_pcnt[1] != '0)
                                     || (r_ccnt[0] != '0) || (r_ccnt[1] != '0);
                if ((r_ccnt[0] != '0) && (r_ccnt[1] != '0)) begin
                    r_res.book_ok     <= 1'b1;
                    r_res.mid_twice   <= {1'b0, r_cp[0][0]} + {1'b0, r_cp[1][0]};
                    r_res.ask_bid_gap <= {1'b0, r_cp[1][0]} - {1'b0, r_cp[0][0]};
                end else begin
                    r_res.book_ok     <= 1'b0;
                    r_res.mid_twice   <= '0;
                    r_res.ask_bid_gap <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_POP;
            r_valid <= 1'b0;
            r_over  <= 1'b0;
            r_j     <= '0;
            for (int s = 0; s < 2; s++) begin
                r_ccnt[s] <= '0;
                r_pcnt[s] <= '0;
                for (int j = 0; j < TOP_N; j++) begin
                    r_seen[s][j] <= 1'b0;
                end
            end
            for (int k = 0; k < NDEPTH; k++) begin
                r_acc[k] <= '0;
            end
        end else begin
            if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_POP: begin
                    if (o_pop) begin
                        r_j <= '0;
                        if (i_cmd.over) begin
                            r_over <= 1'b1;
                        end
                        if (i_cmd.top) begin
                            r_ccnt[i_cmd.side] <= i_cmd.idx + IDX_W'(1);
                            for (int j = 0; j < TOP_N; j++) begin
                                if (match[j]) begin
                                    r_seen[i_cmd.side][j] <= 1'b1;
                                end
                            end
                            r_state <= S_ACC;
                        end else if (i_cmd.last) begin
                            r_state <= S_SWEEP;
                        end
                    end
                end
                S_ACC: begin
                    for (int k = 0; k < NDEPTH; k++) begin
                        if (r_cmd.idx < IDX_W'(DEPTH_K[k])) begin
                            r_acc[k] <= r_cmd.side ? r_acc[k] - delta_x[k]
                                                   : r_acc[k] + delta_x[k];
                        end
                    end
                    r_state <= r_cmd.last ? S_SWEEP : S_POP;
                end
                S_SWEEP: begin
                    for (int k = 0; k < NDEPTH; k++) begin
                        r_acc[k] <= r_acc[k] + sweep_add[k];
                    end
                    r_j <= r_j + IDX_W'(1);
                    if (r_j == IDX_W'(TOP_N - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_valid <= 1'b1;
                        r_over  <= 1'b0;
                        for (int s = 0; s < 2; s++) begin
                            r_pcnt[s] <= r_over ? '0 : r_ccnt[s];
                            r_ccnt[s] <= '0;
                            for (int j = 0; j < TOP_N; j++) begin
                                r_seen[s][j] <= 1'b0;
                            end
                        end
                        for (int k = 0; k < NDEPTH; k++) begin
                            r_acc[k] <= '0;
                        end
                        r_state <= S_POP;
                    end
                end
                default: r_state <= S_POP;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> rtl/book_snapshot_order_flow_imbalance.sv
// top level: multi-level order flow imbalance over consecutive book snapshots
//
//  channel  | dir | transaction
//  ---------+-----+------------------------------------------------------
//  i_lvl    | in  | one book level (side, price, qty, present, last)
//  o_res    | out | one result per snapshot, on the last level
//  i_cfg    | in  | max_qty register write, always ready
//
// a level inside the best ten of its side is matched against the previous view
// in S_POP and then accumulated in S_ACC; other items pass through S_POP only
// closing a snapshot adds a sweep of the previous levels in S_SWEEP and the emit
// in S_DONE, which waits until the result register is free
// reset is synchronous active low and empties both views, max_qty goes to all ones
// the two-entry queue lets the front keep accepting while the back works or
// the result register waits on o_res.ready
`default_nettype none
module book_snapshot_order_flow_imbalance #(
    parameter int LEVELS = 10
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    bsofi_in_if.sink     i_lvl,
    bsofi_out_if.source  o_res,
    bsofi_cfg_if.sink    i_cfg
);
    import bsofi_pkg::*;

    t_cmd push_cmd;
    t_cmd pop_cmd;
    t_res res;
    logic push;
    logic pop;
    logic full;
    logic empty;

    // front counts levels per side, drops those past LEVELS, checks max_qty
    bsofi_front #(.LEVELS(LEVELS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_lvl   (i_lvl),
        .i_cfg   (i_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    bsofi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (pop_cmd)
    );

    // back holds the best ten levels of both views and the running sums
    bsofi_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (pop_cmd),
        .o_pop   (pop),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_res   (res)
    );

    assign o_res.ofi_depth1  = res.ofi_depth1;
    assign o_res.ofi_depth3  = res.ofi_depth3;
    assign o_res.ofi_depth5  = res.ofi_depth5;
    assign o_res.ofi_depth10 = res.ofi_depth10;
    assign o_res.ofi_valid   = res.ofi_valid;
    assign o_res.book_ok     = res.book_ok;
    assign o_res.oversized   = res.oversized;
    assign o_res.mid_twice   = res.mid_twice;
    assign o_res.ask_bid_gap = res.ask_bid_gap;
endmodule
`default_nettype wire

>>> test/tb_top.sv
// testbench for the multi-level order flow imbalance block: random book snapshots
// are checked result by result against a behavioural model of the block
`default_nettype none
module tb_top;
    import bsofi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NLEV      = 10;
    localparam int WDOG_MAX  = 20000;
    localparam int DRAIN_CYC = 64;

    // idling phases
    typedef enum int {PH_NONE, PH_SRC, PH_SNK, PH_BOTH} t_phase;

    typedef struct packed {
        logic        side;
        logic [31:0] price;
        logic [31:0] qty;
        logic        present;
        logic        last;
    } t_lvl;

    logic i_clk;
    logic i_rst_n;

    bsofi_in_if  lvl_if ();
    bsofi_out_if res_if ();
    bsofi_cfg_if cfg_if ();

    book_snapshot_order_flow_imbalance #(.LEVELS(NLEV)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_lvl   (lvl_if.sink),
        .o_res   (res_if.source),
        .i_cfg   (cfg_if.sink)
    );

    // pending level transactions and expected results
    t_lvl level_queue[$];
    t_res result_queue[$];

    // model state of the book views
    logic [31:0] mdl_max_qty;
    logic [31:0] prev_px [2][NLEV];
    logic [31:0] prev_sz [2][NLEV];
    int          prev_cnt [2];
    logic [31:0] cur_px  [2][NLEV];
    logic [31:0] cur_sz  [2][NLEV];
    int          cur_cnt  [2];
    bit          cur_over;

    t_phase phase;
    bit     lvl_taken;
    int     errors;
    int     wdog;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // append one level transaction to the pending list
    task automatic add_level(t_lvl t);
        level_queue = {level_queue, t};
    endtask

    // depth change of one side over the union of old and new best k prices
    function automatic longint side_change(int sd, int k);
        int np;
        int nc;
        longint d;
        longint pq;
        bit seen;
        np = (prev_cnt[sd] < k) ? prev_cnt[sd] : k;
        nc = (cur_cnt[sd] < k) ? cur_cnt[sd] : k;
        d = 0;
        for (int i = 0; i < nc; i++) begin
            pq = 0;
            for (int j = 0; j < np; j++) begin
                if (prev_px[sd][j] == cur_px[sd][i]) begin
                    pq = prev_sz[sd][j];
                    break;
                end
            end
            d += longint'(cur_sz[sd][i]) - pq;
        end
        for (int j = 0; j < np; j++) begin
            seen = 0;
            for (int i = 0; i < nc; i++) begin
                if (cur_px[sd][i] == prev_px[sd][j]) begin
                    seen = 1;
                    break;
                end
            end
            if (!seen) d -= longint'(prev_sz[sd][j]);
        end
        return d;
    endfunction

    // apply one accepted level, queueing the snapshot result on the last one
    task automatic predict_imbalance(t_lvl t);
        t_res r;
        longint v [4];
        int sd;
        sd = t.side;
        if (t.present && cur_cnt[sd] < NLEV) begin
            cur_px[sd][cur_cnt[sd]] = t.price;
            cur_sz[sd][cur_cnt[sd]] = t.qty;
            cur_cnt[sd]++;
            if (t.qty > mdl_max_qty) cur_over = 1;
        end
        if (!t.last) return;
        r = '0;
        if (cur_over) begin
            r.oversized = 1'b1;
            prev_cnt[0] = 0;
            prev_cnt[1] = 0;
        end else begin
            for (int i = 0; i < 4; i++)
                v[i] = side_change(0, DEPTH_K[i]) - side_change(1, DEPTH_K[i]);
            r.ofi_depth1  = v[0][38:0];
            r.ofi_depth3  = v[1][38:0];
            r.ofi_depth5  = v[2][38:0];
            r.ofi_depth10 = v[3][38:0];
            r.ofi_valid = (prev_cnt[0] || prev_cnt[1] || cur_cnt[0] || cur_cnt[1]);
            if (cur_cnt[0] && cur_cnt[1]) begin
                r.book_ok     = 1'b1;
                r.mid_twice   = {1'b0, cur_px[0][0]} + {1'b0, cur_px[1][0]};
                r.ask_bid_gap = {1'b0, cur_px[1][0]} - {1'b0, cur_px[0][0]};
            end
            prev_px  = cur_px;
            prev_sz  = cur_sz;
            prev_cnt = cur_cnt;
        end
        cur_cnt[0] = 0;
        cur_cnt[1] = 0;
        cur_over = 0;
        result_queue = {result_queue, r};
    endtask

    // driver: inputs change on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            lvl_if.valid <= 1'b0;
        end else if (!lvl_if.valid || lvl_taken) begin
            // previous transaction taken (or none): choose the next one
            if (lvl_taken) void'(level_queue.pop_front());
            lvl_taken = 1'b0;
            if (level_queue.size() != 0
                    && !((phase == PH_SRC && $urandom_range(99) < 69)
                         || (phase == PH_BOTH && $urandom_range(99) < 9))) begin
                lvl_if.valid <= 1'b1;
                {lvl_if.side, lvl_if.price, lvl_if.qty, lvl_if.present, lvl_if.last}
                    <= level_queue[0];
            end else begin
                lvl_if.valid <= 1'b0;
            end
        end
        res_if.ready <= !((phase == PH_SNK && $urandom_range(99) < 69)
                          || (phase == PH_BOTH && $urandom_range(99) < 9));
    end

    // monitor: sample on the rising edge
    always @(posedge i_clk) begin
        t_res got;
        t_res exp_r;
        if (i_rst_n) begin
            if ((lvl_if.valid && lvl_if.ready) || (cfg_if.valid && cfg_if.ready)
                    || (res_if.valid && res_if.ready)) begin
                wdog <= 0;
            end else begin
                wdog <= wdog + 1;
            end
            if (lvl_if.valid && lvl_if.ready) begin
                lvl_taken = 1'b1;
                predict_imbalance({lvl_if.side, lvl_if.price, lvl_if.qty,
                                   lvl_if.present, lvl_if.last});
            end
            if (cfg_if.valid && cfg_if.ready) begin
                mdl_max_qty = cfg_if.max_qty;
            end
            if (res_if.valid && res_if.ready) begin
                got = {res_if.ofi_depth1, res_if.ofi_depth3, res_if.ofi_depth5,
                       res_if.ofi_depth10, res_if.ofi_valid, res_if.book_ok,
                       res_if.oversized, res_if.mid_twice, res_if.ask_bid_gap};
                if (result_queue.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end else begin
                    exp_r = result_queue.pop_front();
                    if (got.ofi_depth1 !== exp_r.ofi_depth1)
                        $display("%0t: ofi_depth1 exp %h got %h", $time,
                                 exp_r.ofi_depth1, got.ofi_depth1);
                    if (got.ofi_depth3 !== exp_r.ofi_depth3)
                        $display("%0t: ofi_depth3 exp %h got %h", $time,
                                 exp_r.ofi_depth3, got.ofi_depth3);
                    if (got.ofi_depth5 !== exp_r.ofi_depth5)
                        $display("%0t: ofi_depth5 exp %h got %h", $time,
                                 exp_r.ofi_depth5, got.ofi_depth5);
                    if (got.ofi_depth10 !== exp_r.ofi_depth10)
                        $display("%0t: ofi_depth10 exp %h got %h", $time,
                                 exp_r.ofi_depth10, got.ofi_depth10);
                    if (got.ofi_valid !== exp_r.ofi_valid)
                        $display("%0t: ofi_valid exp %b got %b", $time,
                                 exp_r.ofi_valid, got.ofi_valid);
                    if (got.book_ok !== exp_r.book_ok)
                        $display("%0t: book_ok exp %b got %b", $time,
                                 exp_r.book_ok, got.book_ok);
                    if (got.oversized !== exp_r.oversized)
                        $display("%0t: oversized exp %b got %b", $time,
                                 exp_r.oversized, got.oversized);
                    if (got.mid_twice !== exp_r.mid_twice)
                        $display("%0t: mid_twice exp %h got %h", $time,
                                 exp_r.mid_twice, got.mid_twice);
                    if (got.ask_bid_gap !== exp_r.ask_bid_gap)
                        $display("%0t: ask_bid_gap exp %h got %h", $time,
                                 exp_r.ask_bid_gap, got.ask_bid_gap);
                    if (got !== exp_r) errors++;
                end
            end
            if (wdog >= WDOG_MAX) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // one random level transaction
    function automatic t_lvl rand_level(bit sd, logic [31:0] px, bit wide_qty);
        t_lvl t;
        t.side    = sd;
        t.price   = px;
        t.qty     = wide_qty ? $urandom() : $urandom_range(1000);
        t.present = 1'b1;
        t.last    = 1'b0;
        return t;
    endfunction

    // a well formed snapshot: bids descending, asks ascending, closed by a marker item or by last on its final level
    task automatic add_snapshot(int nb, int na, bit close_item);
        t_lvl t;
        logic [31:0] base;
        bit wide;
        wide = ($urandom_range(9) == 0);
        base = wide ? $urandom() : 32'd1000 + $urandom_range(20);
        for (int i = 0; i < nb; i++)
            add_level(rand_level(1'b0, base - i - $urandom_range(1), wide));
        for (int i = 0; i < na; i++)
            add_level(rand_level(1'b1, base + 1 + i + $urandom_range(1), wide));
        if (close_item || level_queue.size() == 0 || nb + na == 0) begin
            t = '0;
            t.present = 1'b0;
            t.last    = 1'b1;
            t.side    = 1'($urandom_range(1));
            t.price   = $urandom();
            t.qty     = $urandom();
            add_level(t);
        end else begin
            level_queue[$].last = 1'b1;
        end
    endtask

    // wait until the driver is empty and no result is outstanding
    task automatic drain();
        while (level_queue.size() != 0 || lvl_if.valid || result_queue.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // register write while the block is idle
    task automatic write_max_qty(logic [31:0] v);
        drain();
        @(negedge i_clk);
        cfg_if.valid   <= 1'b1;
        cfg_if.max_qty <= v;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic random_part(int n);
        t_lvl t;
        int target;
        target = level_queue.size() + n;
        while (level_queue.size() < target) begin
            case ($urandom_range(9))
                0: begin
                    // noise: stray level or level with garbage
                    t = {1'($urandom_range(1)), $urandom(), $urandom(),
                         1'($urandom_range(1)), 1'b0};
                    add_level(t);
                end
                1: add_snapshot($urandom_range(13), $urandom_range(13),
                                $urandom_range(1) == 1);
                2: add_snapshot($urandom_range(1) ? 0 : $urandom_range(3), 0, 1);
                default: add_snapshot($urandom_range(1, 11), $urandom_range(1, 11),
                                      $urandom_range(3) == 0);
            endcase
        end
    endtask

    initial begin
        t_lvl t;
        errors = 0;
        wdog = 0;
        lvl_taken = 0;
        phase = PH_NONE;
        mdl_max_qty = 32'hFFFF_FFFF;
        prev_cnt = '{0, 0};
        cur_cnt  = '{0, 0};
        cur_over = 0;
        i_rst_n = 1'b0;
        lvl_if.valid = 1'b0;
        lvl_if.side = 1'b0;
        lvl_if.price = '0;
        lvl_if.qty = '0;
        lvl_if.present = 1'b0;
        lvl_if.last = 1'b0;
        res_if.ready = 1'b1;
        cfg_if.valid = 1'b0;
        cfg_if.max_qty = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty books, extremes, one-sided, crossed, overflowing side
        add_snapshot(0, 0, 1);
        add_snapshot(0, 0, 1);
        t = '{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0};
        add_level(t);
        t = '{1'b1, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b1};
        add_level(t);
        t = '{1'b1, 32'h0, 32'h0, 1'b1, 1'b1};
        add_level(t);
        // duplicate prices on one side
        t = '{1'b0, 32'd50, 32'd7, 1'b1, 1'b0};
        add_level(t);
        t = '{1'b0, 32'd50, 32'd9, 1'b1, 1'b0};
        add_level(t);
        t = '{1'b1, 32'd40, 32'd3, 1'b0, 1'b0};
        add_level(t);
        t = '{1'b1, 32'd40, 32'd3, 1'b1, 1'b1};
        add_level(t);
        add_snapshot(12, 1, 0);
        drain();

        // oversized views at the smallest threshold, the all ones one checked above
        write_max_qty(32'h0);
        add_snapshot(2, 2, 0);
        add_snapshot(1, 1, 1);
        t = '{1'b1, 32'd5, 32'd0, 1'b1, 1'b1};
        add_level(t);
        write_max_qty(32'd500);
        random_part(300);
        phase = PH_SRC;
        random_part(300);
        // sender waits for every result before carrying on
        drain();
        write_max_qty(32'hFFFF_FFFF);
        phase = PH_SNK;
        random_part(500);
        phase = PH_BOTH;
        random_part(400);
        write_max_qty($urandom());
        phase = PH_NONE;
        random_part(500);
        drain();

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
